// File: src/dsc_pkg.sv
// ----------------------------------------------------------------------------
// dsc_pkg: shared constants for the distinct subsequence counter
// Alphabet size, symbol and count widths.
// ----------------------------------------------------------------------------
package dsc_pkg;

  localparam int ALPHABET_SIZE = 256;
  localparam int SYM_W         = $clog2(ALPHABET_SIZE);
  localparam int SYMBOL_W      = 8;
  localparam int COUNT_W       = 64;

endpackage

// File: src/dsc_ram.sv
// ----------------------------------------------------------------------------
// dsc_ram: generic single-write, single-read RAM
// Registered read, read-first on a same-address write; read data holds
// while the read enable is low.
// ----------------------------------------------------------------------------
module dsc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/distinct_subsequence_counter_unit.sv
// ----------------------------------------------------------------------------
// distinct_subsequence_counter_unit: running distinct subsequence count
// Takes one symbol per request and returns the count of distinct
// subsequences of the string so far (empty one included), modulo 2^64.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------
//  symbol   | sym_valid / sym_stall   | symbol[7:0], starts_string
//  count    | count_valid/count_stall | subsequence_count[63:0]
//
// Rate: one request per clock while results are not stalled; a result
//   passes the registered table RAM read (compute stage) and then the
//   output register.
// Latency is set by the registered read of the per-symbol table RAM and the output register.
// Reset: running count goes to 1 and every seen mark clears.
//   The table RAM itself is not cleared; an entry is only used once its
//   seen mark is set, which happens only together with a write to it.
// Stalls: a stalled result holds in the output register; the compute
//   stage keeps its item, and sym_stall rises only when that stage is
//   full and cannot move.
// ----------------------------------------------------------------------------
module distinct_subsequence_counter_unit
  import dsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                sym_valid,
  output logic                sym_stall,
  input  logic [SYMBOL_W-1:0] symbol,
  input  logic                starts_string,
  output logic                count_valid,
  input  logic                count_stall,
  output logic [COUNT_W-1:0]  subsequence_count
);

  // Compute stage (item whose table read is in flight / done)
  logic               s1_valid;
  logic [SYM_W-1:0]   s1_sym;
  logic               s1_start;
  logic               s1_fwd;       // table entry was rewritten as it was read
  logic [COUNT_W-1:0] s1_fwd_data;

  logic [COUNT_W-1:0]       running_count;
  logic [ALPHABET_SIZE-1:0] seen;
  logic [ALPHABET_SIZE-1:0] seen_next;

  logic               s1_advance;
  logic               accept;
  logic [SYM_W-1:0]   in_idx;
  logic               wr_en;
  logic [COUNT_W-1:0] old_count;
  logic [COUNT_W-1:0] ram_rdata;
  logic [COUNT_W-1:0] prev_raw;
  logic [COUNT_W-1:0] prev;
  logic               prev_seen;
  logic [COUNT_W-1:0] fresh;

  // symbol modulo alphabet size (power of two: keep low bits)
  assign in_idx = SYM_W'(symbol % ALPHABET_SIZE);

  assign s1_advance = s1_valid && (!count_valid || !count_stall);
  assign sym_stall  = s1_valid && !s1_advance;
  assign accept     = sym_valid && !sym_stall;
  assign wr_en      = s1_advance;

  // start flag restarts from count 1 with every mark cleared
  assign old_count = s1_start ? COUNT_W'(1) : running_count;
  assign prev_seen = !s1_start && seen[s1_sym];
  assign prev_raw  = s1_fwd ? s1_fwd_data : ram_rdata;
  assign prev      = prev_seen ? prev_raw : '0;
  assign fresh     = (old_count << 1) - prev;

  // marks after this item: cleared on a string start, own symbol set
  always_comb begin
    seen_next         = s1_start ? '0 : seen;
    seen_next[s1_sym] = 1'b1;
  end

  dsc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (ALPHABET_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_sym),
    .wdata (old_count),
    .re    (accept),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      count_valid   <= 1'b0;
      running_count <= COUNT_W'(1);
      seen          <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end

      if (s1_advance) begin
        count_valid <= 1'b1;
      end else if (!count_stall) begin
        count_valid <= 1'b0;
      end

      if (wr_en) begin
        running_count <= fresh;
        seen          <= seen_next;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sym      <= in_idx;
      s1_start    <= starts_string;
      // read-first RAM: same-entry write at this edge is forwarded
      s1_fwd      <= wr_en && (s1_sym == in_idx);
      s1_fwd_data <= old_count;
    end
    if (s1_advance) begin
      subsequence_count <= fresh;
    end
  end

  // Assertions
  a_stall_needs_item : assert property (@(posedge clk) disable iff (rst)
    sym_stall |-> (s1_valid && count_valid && count_stall))
    else $error("symbol stall without a blocked item");

  a_start_gives_two : assert property (@(posedge clk) disable iff (rst)
    (wr_en && s1_start) |=> (running_count == COUNT_W'(2)))
    else $error("string start did not yield count 2");

  a_mark_set : assert property (@(posedge clk) disable iff (rst)
    wr_en |=> seen[$past(s1_sym)])
    else $error("seen mark not set after table write");

  a_result_tracks_count : assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (count_valid && subsequence_count == running_count))
    else $error("emitted count differs from running count");

endmodule
